// ===== rtl/v2r_pkg.sv =====
// ----------------------------------------------------------------------------
// v2r_pkg: shared types and constants for the v210 to rgba converter
// Holds the group entry passed from the front to the back and the result
// record that goes into the output queue.
// ----------------------------------------------------------------------------
`default_nettype none

package v2r_pkg;

  // samples and sizes
  localparam int SampleBits = 8;
  localparam int LumaCount  = 6;
  localparam int PairCount  = 3;
  localparam int CountBits  = 3;
  localparam int PosBits    = 13;
  localparam int PixelBits  = 32;

  // queue depths
  localparam int EntryDepth = 2;
  localparam int OutDepth   = 4;

  // register indexes on the configuration port
  localparam logic RegFrameWidth  = 1'b0;
  localparam logic RegFrameHeight = 1'b1;

  // reset values of the configuration registers
  localparam logic [PosBits-1:0] WidthReset  = 13'd1920;
  localparam logic [PosBits-1:0] HeightReset = 13'd1080;

  // one classified group, ready for conversion
  typedef struct packed {
    logic [LumaCount-1:0][SampleBits-1:0] y;
    logic [PairCount-1:0][SampleBits-1:0] cb;
    logic [PairCount-1:0][SampleBits-1:0] cr;
    logic [CountBits-1:0]                 count;
    logic                                 line_end;
    logic                                 frame_end;
  } entry_t;

  // one converted pixel with its markers
  typedef struct packed {
    logic [PixelBits-1:0] pixel_word;
    logic                 group_done;
    logic                 line_done;
    logic                 frame_done;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/v2r_fifo.sv =====
// ----------------------------------------------------------------------------
// v2r_fifo: small show-ahead queue
// Register-based queue with occupancy count; the head is always on dout.
// ----------------------------------------------------------------------------
`default_nettype none

module v2r_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       push,
  input  wire logic [WIDTH-1:0]           din,
  input  wire logic                       pop,
  output logic      [WIDTH-1:0]           dout,
  output logic                            full,
  output logic                            empty,
  output logic      [$clog2(DEPTH+1)-1:0] count
);

  localparam int PtrBits = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntBits = $clog2(DEPTH+1);

  logic [WIDTH-1:0]   slots [DEPTH];
  logic [PtrBits-1:0] wr_ptr;
  logic [PtrBits-1:0] rd_ptr;
  logic               do_push;
  logic               do_pop;

  assign full    = (count == CntBits'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= din;
    end
  end

  // pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrBits'(DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrBits'(DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/v2r_front.sv =====
// ----------------------------------------------------------------------------
// v2r_front: group intake and position tracking
// Unpacks a v210 group, works out how many pixels it yields and whether it
// closes a line or a frame, and advances the column and line counters.
// ----------------------------------------------------------------------------
`default_nettype none

module v2r_front #(
  parameter int MAX_LINE_PIXELS = 4096
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        push,
  input  wire logic [31:0]                 word_a,
  input  wire logic [31:0]                 word_b,
  input  wire logic [31:0]                 word_c,
  input  wire logic [31:0]                 word_d,
  input  wire logic [v2r_pkg::PosBits-1:0] width_cfg,
  input  wire logic [v2r_pkg::PosBits-1:0] height_cfg,
  input  wire logic                        q_full,
  output logic                             q_push,
  output v2r_pkg::entry_t                  q_entry
);

  localparam int PB = v2r_pkg::PosBits;

  logic [PB-1:0]                  column_position;
  logic [PB-1:0]                  line_position;
  logic [PB-1:0]                  column_position_next;
  logic [PB-1:0]                  line_position_next;
  logic [PB-1:0]                  width_eff;
  logic [PB-1:0]                  height_eff;
  logic [PB-1:0]                  col;
  logic [PB-1:0]                  rem;
  logic [PB:0]                    line_plus;
  logic [v2r_pkg::CountBits-1:0]  count;
  logic                           line_end;
  logic                           frame_end;

  assign q_push = push && !q_full;

  // effective frame size
  always_comb begin
    width_eff = width_cfg;
    if (width_cfg == '0) begin
      width_eff = PB'(1);
    end else if (32'(width_cfg) > MAX_LINE_PIXELS) begin
      width_eff = PB'(MAX_LINE_PIXELS);
    end
    height_eff = (height_cfg == '0) ? PB'(1) : height_cfg;
  end

  // pixel count and line / frame end for this group
  always_comb begin
    col       = (column_position >= width_eff) ? '0 : column_position;
    rem       = width_eff - col;
    count     = (rem > PB'(6)) ? v2r_pkg::CountBits'(6) : rem[v2r_pkg::CountBits-1:0];
    line_end  = (rem <= PB'(6));
    line_plus = {1'b0, line_position} + (PB+1)'(1);
    frame_end = line_end && (line_plus >= {1'b0, height_eff});
  end

  // next position
  always_comb begin
    column_position_next = col + PB'(count);
    line_position_next   = line_position;
    if (line_end) begin
      column_position_next = '0;
      line_position_next   = frame_end ? '0 : line_plus[PB-1:0];
    end
  end

  // sample unpacking, two low bits dropped
  always_comb begin
    q_entry.cb[0]     = word_a[9:2];
    q_entry.y[0]      = word_a[19:12];
    q_entry.cr[0]     = word_a[29:22];
    q_entry.y[1]      = word_b[9:2];
    q_entry.cb[1]     = word_b[19:12];
    q_entry.y[2]      = word_b[29:22];
    q_entry.cr[1]     = word_c[9:2];
    q_entry.y[3]      = word_c[19:12];
    q_entry.cb[2]     = word_c[29:22];
    q_entry.y[4]      = word_d[9:2];
    q_entry.cr[2]     = word_d[19:12];
    q_entry.y[5]      = word_d[29:22];
    q_entry.count     = count;
    q_entry.line_end  = line_end;
    q_entry.frame_end = frame_end;
  end

  // position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      column_position <= '0;
      line_position   <= '0;
    end else if (q_push) begin
      column_position <= column_position_next;
      line_position   <= line_position_next;
    end
  end

  // a group always yields one to six pixels
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    q_push |-> (count != '0 && count <= v2r_pkg::CountBits'(6)))
    else $error("group pixel count out of range");

  // a frame end is always also a line end and returns both counters to zero
  a_frame_on_line: assert property (@(posedge clk) disable iff (rst)
    q_push && frame_end |=> column_position == '0 && line_position == '0)
    else $error("frame end did not return to origin");

  // the column never passes the effective width after a push
  a_column_bound: assert property (@(posedge clk) disable iff (rst)
    q_push |=> column_position < $past(width_eff))
    else $error("column beyond width");

endmodule

`default_nettype wire

// ===== rtl/v2r_back.sv =====
// ----------------------------------------------------------------------------
// v2r_back: pixel sequencer and color conversion
// Steps through the head group's pixels one per cycle while the output has
// room; multiplies chroma by fixed-point coefficients, sums, clamps, packs.
// ----------------------------------------------------------------------------
`default_nettype none

module v2r_back #(
  parameter int COEF_FRAC_BITS = 16
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire v2r_pkg::entry_t                         q_entry,
  input  wire logic                                    q_empty,
  output logic                                         q_pop,
  input  wire logic [$clog2(v2r_pkg::OutDepth+1)-1:0]  out_count,
  output logic                                         out_push,
  output v2r_pkg::result_t                             out_result
);

  localparam int F          = COEF_FRAC_BITS;
  localparam int KW         = F + 2;
  localparam int PW         = KW + 9;
  localparam int ACC_W      = F + 12;
  localparam int OutCntBits = $clog2(v2r_pkg::OutDepth+1);
  localparam int OccBits    = OutCntBits + 1;

  // coefficients, rounded with ties up
  localparam logic signed [KW-1:0] KR  =
    KW'((64'(15748) * (64'(1) << F) + 64'(5000)) / 64'(10000));
  localparam logic signed [KW-1:0] KGU =
    KW'((64'(1873) * (64'(1) << F) + 64'(5000)) / 64'(10000));
  localparam logic signed [KW-1:0] KGV =
    KW'((64'(4681) * (64'(1) << F) + 64'(5000)) / 64'(10000));
  localparam logic signed [KW-1:0] KB  =
    KW'((64'(18556) * (64'(1) << F) + 64'(5000)) / 64'(10000));

  logic [v2r_pkg::CountBits-1:0] idx;
  logic [OccBits-1:0]            occupancy;
  logic                          issue;
  logic                          last;
  logic [1:0]                    pair;
  logic [7:0]                    sel_y;
  logic signed [8:0]             u;
  logic signed [8:0]             v;

  // multiply stage registers
  logic                          a_valid;
  logic [7:0]                    a_y;
  logic signed [PW-1:0]          a_pr;
  logic signed [PW-1:0]          a_pgu;
  logic signed [PW-1:0]          a_pgv;
  logic signed [PW-1:0]          a_pb;
  logic                          a_group_done;
  logic                          a_line_done;
  logic                          a_frame_done;

  // sum stage registers
  logic                          b_valid;
  v2r_pkg::result_t              b_result;

  logic signed [ACC_W-1:0]       yy;
  logic signed [ACC_W-1:0]       acc_r;
  logic signed [ACC_W-1:0]       acc_g;
  logic signed [ACC_W-1:0]       acc_b;
  logic [7:0]                    red;
  logic [7:0]                    green;
  logic [7:0]                    blue;

  function automatic logic [7:0] clamp_channel(input logic signed [ACC_W-1:0] acc);
    logic [7:0] res;
    if (acc[ACC_W-1]) begin
      res = 8'd0;
    end else if (|acc[ACC_W-2:F+8]) begin
      res = 8'd255;
    end else begin
      res = acc[F+7:F];
    end
    return res;
  endfunction

  // issue control, keeps room in the output queue for pixels in flight
  assign occupancy = OccBits'(out_count) + OccBits'(a_valid) + OccBits'(b_valid);
  assign issue     = !q_empty && (occupancy < OccBits'(v2r_pkg::OutDepth));
  assign last      = (idx == q_entry.count - 1'b1);
  assign q_pop     = issue && last;

  // sample selection, chroma roles swapped
  always_comb begin
    pair  = 2'(idx >> 1);
    sel_y = q_entry.y[idx];
    u     = $signed({1'b0, q_entry.cr[pair]}) - 9'sd128;
    v     = $signed({1'b0, q_entry.cb[pair]}) - 9'sd128;
  end

  // pixel index within the head group
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (issue) begin
      idx <= last ? '0 : idx + 1'b1;
    end
  end

  // multiply stage
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      a_y          <= sel_y;
      a_pr         <= KR * v;
      a_pgu        <= KGU * u;
      a_pgv        <= KGV * v;
      a_pb         <= KB * u;
      a_group_done <= last;
      a_line_done  <= last && q_entry.line_end;
      a_frame_done <= last && q_entry.frame_end;
    end
  end

  // sum and clamp
  always_comb begin
    yy    = $signed({{(ACC_W-8-F){1'b0}}, a_y, {F{1'b0}}});
    acc_r = yy + ACC_W'(a_pr);
    acc_g = yy - ACC_W'(a_pgu) - ACC_W'(a_pgv);
    acc_b = yy + ACC_W'(a_pb);
    red   = clamp_channel(acc_r);
    green = clamp_channel(acc_g);
    blue  = clamp_channel(acc_b);
  end

  // sum stage
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_valid) begin
      b_result.pixel_word <= {8'hFF, red, green, blue};
      b_result.group_done <= a_group_done;
      b_result.line_done  <= a_line_done;
      b_result.frame_done <= a_frame_done;
    end
  end

  assign out_push   = b_valid;
  assign out_result = b_result;

  // the output queue always has room for a finished pixel
  a_out_room: assert property (@(posedge clk) disable iff (rst)
    b_valid |-> out_count < OutCntBits'(v2r_pkg::OutDepth))
    else $error("output queue overrun");

  // a pixel is only started from a waiting group
  a_issue_src: assert property (@(posedge clk) disable iff (rst)
    issue |-> !q_empty && q_entry.count != '0)
    else $error("issue without a group");

  // the index stays inside the head group
  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    !q_empty |-> idx < q_entry.count)
    else $error("pixel index beyond group");

endmodule

`default_nettype wire

// ===== rtl/v210_to_rgba_converter.sv =====
// ----------------------------------------------------------------------------
// v210_to_rgba_converter: v210 group to packed ARGB pixels
// The first pixel of a group reaches the result ports through the group
// queue, the multiply stage, the sum stage and the result queue.
// Throughput: one pixel per cycle from the conversion pipeline while the
// result queue has room; a two-entry group queue and a four-entry result
// queue let intake and output stall independently.
// Reset (rst, synchronous): queues empty, column and line counters at zero,
// width register 1920, height register 1080.
// ----------------------------------------------------------------------------
`default_nettype none

module v210_to_rgba_converter #(
  parameter int MAX_LINE_PIXELS = 4096,
  parameter int COEF_FRAC_BITS  = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // group intake
  input  wire logic        push,
  output logic             full,
  input  wire logic [31:0] word_a,
  input  wire logic [31:0] word_b,
  input  wire logic [31:0] word_c,
  input  wire logic [31:0] word_d,
  // pixel results
  output logic             empty,
  input  wire logic        pop,
  output logic [31:0]      pixel_word,
  output logic             group_done,
  output logic             line_done,
  output logic             frame_done,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int PB       = v2r_pkg::PosBits;
  localparam int EntryW   = $bits(v2r_pkg::entry_t);
  localparam int ResultW  = $bits(v2r_pkg::result_t);
  localparam int OutCntW  = $clog2(v2r_pkg::OutDepth+1);
  localparam int EntCntW  = $clog2(v2r_pkg::EntryDepth+1);

  logic [PB-1:0]         width_cfg;
  logic [PB-1:0]         height_cfg;
  logic                  cfg_write;

  logic                  q_push;
  logic                  q_pop;
  logic                  q_full;
  logic                  q_empty;
  logic [EntCntW-1:0]    q_count;
  v2r_pkg::entry_t       q_in;
  v2r_pkg::entry_t       q_out;
  logic [EntryW-1:0]     q_out_bits;

  logic                  out_push;
  logic [OutCntW-1:0]    out_count;
  logic                  out_full;
  v2r_pkg::result_t      out_result;
  logic [ResultW-1:0]    out_bits;
  v2r_pkg::result_t      head;

  // configuration registers
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_cfg  <= v2r_pkg::WidthReset;
      height_cfg <= v2r_pkg::HeightReset;
    end else if (cfg_write) begin
      if (paddr[2] == v2r_pkg::RegFrameWidth) begin
        width_cfg <= pwdata[PB-1:0];
      end else begin
        height_cfg <= pwdata[PB-1:0];
      end
    end
  end

  // register readback
  always_comb begin
    if (paddr[2] == v2r_pkg::RegFrameHeight) begin
      prdata = {{(32-PB){1'b0}}, height_cfg};
    end else begin
      prdata = {{(32-PB){1'b0}}, width_cfg};
    end
  end

  // group intake
  v2r_front #(
    .MAX_LINE_PIXELS(MAX_LINE_PIXELS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .word_a       (word_a),
    .word_b       (word_b),
    .word_c       (word_c),
    .word_d       (word_d),
    .width_cfg    (width_cfg),
    .height_cfg   (height_cfg),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_entry      (q_in)
  );

  assign full = q_full;

  // group queue between intake and conversion
  v2r_fifo #(
    .WIDTH(EntryW),
    .DEPTH(v2r_pkg::EntryDepth)
  ) u_group_q (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_in),
    .pop   (q_pop),
    .dout  (q_out_bits),
    .full  (q_full),
    .empty (q_empty),
    .count (q_count)
  );

  assign q_out = v2r_pkg::entry_t'(q_out_bits);

  // conversion pipeline
  v2r_back #(
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_entry    (q_out),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .out_count  (out_count),
    .out_push   (out_push),
    .out_result (out_result)
  );

  // result queue
  v2r_fifo #(
    .WIDTH(ResultW),
    .DEPTH(v2r_pkg::OutDepth)
  ) u_result_q (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .din   (out_result),
    .pop   (pop),
    .dout  (out_bits),
    .full  (out_full),
    .empty (empty),
    .count (out_count)
  );

  assign head       = v2r_pkg::result_t'(out_bits);
  assign pixel_word = head.pixel_word;
  assign group_done = head.group_done;
  assign line_done  = head.line_done;
  assign frame_done = head.frame_done;

  // group queue count matches its empty flag
  a_q_flags: assert property (@(posedge clk) disable iff (rst)
    (q_count == '0) == q_empty)
    else $error("group queue flag mismatch");

  // result queue is never pushed while full
  a_out_nofull: assert property (@(posedge clk) disable iff (rst)
    out_push |-> !out_full)
    else $error("result queue pushed while full");

  // a pop of the group queue always follows a waiting group
  a_q_pop: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("group queue popped while empty");

endmodule

`default_nettype wire
